// ===== rtl/apts_pkg.sv =====
`default_nettype none

package apts_pkg;

  // Fixed field widths of the configuration registers and the result.
  localparam int unsigned NUM_W      = 16;
  localparam int unsigned DEN_W      = 31;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned GAP_W      = 12;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned OUT_W      = 48;
  localparam int unsigned MULT_W     = NUM_W + RATE_W;
  localparam int unsigned GAP_US_W   = GAP_W + RATE_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // Microseconds per second.
  localparam logic [RATE_W-1:0] US_PER_SEC = 20'd1000000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_NUM      = 3'd0,
    REG_TICK_DEN      = 3'd1,
    REG_SAMPLE_RATE   = 3'd2,
    REG_GAP_SECONDS   = 3'd3,
    REG_UNWRAP_EN     = 3'd4,
    REG_ALLOW_REGRESS = 3'd5
  } cfg_reg_t;

  // Rescaling operations of the shared multiply-divide unit.
  typedef enum logic [1:0] {
    OP_PTS_SAMPLES = 2'd0,
    OP_CLOCK_US    = 2'd1,
    OP_PTS_US      = 2'd2
  } scale_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      start;
    scale_op_t op;
    logic      cap_psamp;
    logic      cap_exp;
    logic      cap_act;
    logic      check;
    logic      cap_out;
    logic      finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pts_valid;
    logic scale_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/apts_scaler.sv =====
`default_nettype none

// Computes round(v * m / d) with ties away from zero, saturated to 2^VW-1.
// Shift-add multiply, one multiplier bit per cycle, then restoring division,
// one quotient bit per cycle.
module apts_scaler #(
  parameter int unsigned VW = 48,
  parameter int unsigned MW = 36,
  parameter int unsigned DW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [VW-1:0] v,
  input  wire logic [MW-1:0] m,
  input  wire logic [DW-1:0] d,
  output logic               done,
  output logic [VW-1:0]      result
);

  localparam int unsigned PW = VW + MW;
  localparam int unsigned NW = PW + 1;
  localparam int unsigned CW = $clog2(NW);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_PREP, S_DIV} sc_state_t;

  sc_state_t       state_r;
  logic [CW-1:0]   cnt_r;
  logic [PW-1:0]   acc_r;
  logic [PW-1:0]   vs_r;
  logic [MW-1:0]   m_r;
  logic [DW-1:0]   d_r;
  logic [NW-1:0]   num_r;
  logic [DW-1:0]   rem_r;
  logic [NW-1:0]   q_r;
  logic            done_r;
  logic [VW-1:0]   res_r;

  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;
  logic [NW-1:0]   q_nxt;
  logic            sat;

  // One restoring division step.
  always_comb begin
    rem_sh  = {rem_r, num_r[NW-1]};
    ge      = rem_sh >= {1'b0, d_r};
    rem_sub = rem_sh - {1'b0, d_r};
    q_nxt   = {q_r[NW-2:0], ge};
    sat     = q_nxt[NW-1:VW] != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            acc_r   <= '0;
            vs_r    <= PW'(v);
            m_r     <= m;
            d_r     <= d;
            cnt_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (m_r[0]) begin
            acc_r <= acc_r + vs_r;
          end
          vs_r  <= {vs_r[PW-2:0], 1'b0};
          m_r   <= {1'b0, m_r[MW-1:1]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(MW - 1)) begin
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          num_r   <= {1'b0, acc_r} + NW'(d_r >> 1);
          rem_r   <= '0;
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          num_r <= {num_r[NW-2:0], 1'b0};
          q_r   <= q_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(NW - 1)) begin
            res_r   <= sat ? '1 : q_nxt[VW-1:0];
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

// ===== rtl/apts_dp.sv =====
`default_nettype none

// Datapath: configuration registers, unwrap state, sample clock, the shared
// rescaling unit and the result register.
module apts_dp #(
  parameter int unsigned PTS_BITS  = 33,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [apts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [apts_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [PTS_BITS-1:0]               in_pts,
  input  wire logic                              in_pts_valid,
  input  wire logic [apts_pkg::CNT_W-1:0]        in_sample_count,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic                                   out_emit,
  output logic [apts_pkg::OUT_W-1:0]             out_time_us,
  output logic                                   out_resynced,
  input  wire apts_pkg::dp_cmd_t                 cmd,
  output apts_pkg::dp_status_t                   status
);

  localparam int unsigned SW = TIME_BITS + 3;
  localparam int unsigned PX = PTS_BITS + 2;
  localparam logic [PX-1:0] HALF_U  = {3'b001, {(PTS_BITS - 1){1'b0}}};
  localparam logic [PX-1:0] EPOCH_U = {2'b01, {PTS_BITS{1'b0}}};
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Configuration.
  logic [apts_pkg::NUM_W-1:0]  num_r;
  logic [apts_pkg::DEN_W-1:0]  den_r;
  logic [apts_pkg::RATE_W-1:0] rate_r;
  logic [apts_pkg::GAP_W-1:0]  gap_r;
  logic                        unwrap_en_r;
  logic                        allow_r;

  // Derived constants, refreshed every cycle.
  logic [apts_pkg::MULT_W-1:0]   tick_sr_r;
  logic [apts_pkg::MULT_W-1:0]   tick_us_r;
  logic [apts_pkg::GAP_US_W-1:0] gap_us_r;

  // Tracking state.
  logic [TIME_BITS-1:0] unw_r;
  logic                 unw_seen_r;
  logic [TIME_BITS-1:0] clk_r;
  logic                 any_seen_r;
  logic [TIME_BITS-1:0] last_r;
  logic                 last_set_r;

  // Per-item working registers.
  logic [TIME_BITS-1:0]         p_r;
  logic                         pv_r;
  logic [apts_pkg::CNT_W-1:0]   cnt_r;
  logic [TIME_BITS-1:0]         psamp_r;
  logic [TIME_BITS-1:0]         exp_r;
  logic [TIME_BITS-1:0]         act_r;
  logic [TIME_BITS-1:0]         ous_r;
  logic                         resync_r;

  // Result register.
  logic                         out_valid_r;
  logic                         out_emit_r;
  logic [apts_pkg::OUT_W-1:0]   out_time_r;
  logic                         out_resync_r;

  logic [apts_pkg::DEN_W-1:0]  den_nz;
  logic [apts_pkg::RATE_W-1:0] rate_nz;

  assign den_nz  = (den_r == '0) ? apts_pkg::DEN_W'(1) : den_r;
  assign rate_nz = (rate_r == '0) ? apts_pkg::RATE_W'(1) : rate_r;

  // Rollover unwrap of the incoming timestamp.
  logic signed [PX-1:0] step_raw;
  logic signed [PX-1:0] step_adj;
  logic signed [SW-1:0] unw_sum;
  logic [TIME_BITS-1:0] unw_nxt;
  logic [TIME_BITS-1:0] p_nxt;

  always_comb begin
    step_raw = $signed(PX'(in_pts)) - $signed(PX'(unw_r[PTS_BITS-1:0]));
    if (step_raw > $signed(HALF_U)) begin
      step_adj = step_raw - $signed(EPOCH_U);
    end else if (step_raw < -$signed(HALF_U)) begin
      step_adj = step_raw + $signed(EPOCH_U);
    end else begin
      step_adj = step_raw;
    end
    unw_sum = $signed(SW'(unw_r)) + SW'(step_adj);
    if (!unw_seen_r) begin
      unw_nxt = TIME_BITS'(in_pts);
    end else if (unw_sum[SW-1]) begin
      unw_nxt = '0;
    end else if (unw_sum[SW-2:TIME_BITS] != '0) begin
      unw_nxt = TIME_MAX;
    end else begin
      unw_nxt = unw_sum[TIME_BITS-1:0];
    end
    p_nxt = unwrap_en_r ? unw_nxt : TIME_BITS'(in_pts);
  end

  // Operand selection for the rescaling unit.
  logic [TIME_BITS-1:0]        sc_v;
  logic [apts_pkg::MULT_W-1:0] sc_m;
  logic [apts_pkg::DEN_W-1:0]  sc_d;
  logic                        sc_done;
  logic [TIME_BITS-1:0]        sc_res;

  always_comb begin
    case (cmd.op)
      apts_pkg::OP_PTS_SAMPLES: begin
        sc_v = p_r;
        sc_m = tick_sr_r;
        sc_d = den_nz;
      end
      apts_pkg::OP_PTS_US: begin
        sc_v = p_r;
        sc_m = tick_us_r;
        sc_d = den_nz;
      end
      default: begin
        sc_v = clk_r;
        sc_m = apts_pkg::MULT_W'(apts_pkg::US_PER_SEC);
        sc_d = apts_pkg::DEN_W'(rate_nz);
      end
    endcase
  end

  apts_scaler #(
    .VW (TIME_BITS),
    .MW (apts_pkg::MULT_W),
    .DW (apts_pkg::DEN_W)
  ) u_scaler (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.start),
    .v      (sc_v),
    .m      (sc_m),
    .d      (sc_d),
    .done   (sc_done),
    .result (sc_res)
  );

  // Drift check and result assembly.
  logic [TIME_BITS-1:0] diff;
  logic                 drift_hi;
  logic                 emit_w;
  logic [TIME_BITS:0]   clk_sum;
  logic [TIME_BITS+apts_pkg::OUT_W-1:0] ous_ext;

  always_comb begin
    diff     = (exp_r > act_r) ? (exp_r - act_r) : (act_r - exp_r);
    drift_hi = diff > TIME_BITS'(gap_us_r);
    emit_w   = (cnt_r != '0) && (allow_r || !last_set_r || (ous_r > last_r));
    clk_sum  = {1'b0, clk_r} + (TIME_BITS + 1)'(cnt_r);
    ous_ext  = (TIME_BITS + apts_pkg::OUT_W)'(ous_r);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r       <= apts_pkg::NUM_W'(1);
      den_r       <= apts_pkg::DEN_W'(90000);
      rate_r      <= apts_pkg::RATE_W'(48000);
      gap_r       <= apts_pkg::GAP_W'(5);
      unwrap_en_r <= 1'b0;
      allow_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (apts_pkg::cfg_reg_t'(cfg_index))
        apts_pkg::REG_TICK_NUM:      num_r       <= cfg_wdata[apts_pkg::NUM_W-1:0];
        apts_pkg::REG_TICK_DEN:      den_r       <= cfg_wdata[apts_pkg::DEN_W-1:0];
        apts_pkg::REG_SAMPLE_RATE:   rate_r      <= cfg_wdata[apts_pkg::RATE_W-1:0];
        apts_pkg::REG_GAP_SECONDS:   gap_r       <= cfg_wdata[apts_pkg::GAP_W-1:0];
        apts_pkg::REG_UNWRAP_EN:     unwrap_en_r <= cfg_wdata[0];
        apts_pkg::REG_ALLOW_REGRESS: allow_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Products of configuration values, computed at full product width.
  always_ff @(posedge clk) begin
    tick_sr_r <= apts_pkg::MULT_W'(num_r) * apts_pkg::MULT_W'(rate_nz);
    tick_us_r <= apts_pkg::MULT_W'(num_r) * apts_pkg::MULT_W'(apts_pkg::US_PER_SEC);
    gap_us_r  <= apts_pkg::GAP_US_W'(gap_r) * apts_pkg::GAP_US_W'(apts_pkg::US_PER_SEC);
  end

  // Tracking state and per-item registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unw_r       <= '0;
      unw_seen_r  <= 1'b0;
      clk_r       <= '0;
      any_seen_r  <= 1'b0;
      last_r      <= '0;
      last_set_r  <= 1'b0;
      pv_r        <= 1'b0;
      resync_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        p_r      <= p_nxt;
        pv_r     <= in_pts_valid;
        cnt_r    <= in_sample_count;
        resync_r <= 1'b0;
        if (in_pts_valid && unwrap_en_r) begin
          unw_r      <= unw_nxt;
          unw_seen_r <= 1'b1;
        end
      end
      if (cmd.cap_psamp) begin
        psamp_r <= sc_res;
        if (!any_seen_r) begin
          clk_r <= sc_res;
        end
      end
      if (cmd.cap_exp) begin
        exp_r <= sc_res;
      end
      if (cmd.cap_act) begin
        act_r <= sc_res;
      end
      if (cmd.check && drift_hi) begin
        clk_r    <= psamp_r;
        resync_r <= 1'b1;
      end
      if (cmd.cap_out) begin
        ous_r <= sc_res;
      end
      // The result register frees when taken and loads at the end of an item.
      if (cmd.finish) begin
        out_valid_r  <= 1'b1;
        out_emit_r   <= emit_w;
        out_time_r   <= ous_ext[apts_pkg::OUT_W-1:0];
        out_resync_r <= resync_r;
        any_seen_r   <= 1'b1;
        if (emit_w) begin
          last_r     <= ous_r;
          last_set_r <= 1'b1;
        end
        if (cnt_r != '0) begin
          clk_r <= clk_sum[TIME_BITS] ? TIME_MAX : clk_sum[TIME_BITS-1:0];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_emit     = out_emit_r;
  assign out_time_us  = out_time_r;
  assign out_resynced = out_resync_r;

  assign status.pts_valid  = pv_r;
  assign status.scale_done = sc_done;
  assign status.out_busy   = out_valid_r && out_stall;

endmodule

`default_nettype wire

// ===== rtl/apts_ctrl.sv =====
`default_nettype none

// Sequencer: steps one item through its rescaling passes.
module apts_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output apts_pkg::dp_cmd_t          cmd,
  input  wire apts_pkg::dp_status_t  status
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PSAMP_GO, ST_PSAMP_WAIT, ST_EXP_GO, ST_EXP_WAIT,
    ST_ACT_GO, ST_ACT_WAIT, ST_CHECK, ST_OUT_GO, ST_OUT_WAIT, ST_FINISH
  } ctrl_state_t;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // Commands and next state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = apts_pkg::OP_CLOCK_US;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PSAMP_GO;
        end
      end
      ST_PSAMP_GO: begin
        if (status.pts_valid) begin
          cmd.start = 1'b1;
          cmd.op    = apts_pkg::OP_PTS_SAMPLES;
          state_nxt = ST_PSAMP_WAIT;
        end else begin
          state_nxt = ST_OUT_GO;
        end
      end
      ST_PSAMP_WAIT: begin
        if (status.scale_done) begin
          cmd.cap_psamp = 1'b1;
          state_nxt     = ST_EXP_GO;
        end
      end
      ST_EXP_GO: begin
        cmd.start = 1'b1;
        state_nxt = ST_EXP_WAIT;
      end
      ST_EXP_WAIT: begin
        if (status.scale_done) begin
          cmd.cap_exp = 1'b1;
          state_nxt   = ST_ACT_GO;
        end
      end
      ST_ACT_GO: begin
        cmd.start = 1'b1;
        cmd.op    = apts_pkg::OP_PTS_US;
        state_nxt = ST_ACT_WAIT;
      end
      ST_ACT_WAIT: begin
        if (status.scale_done) begin
          cmd.cap_act = 1'b1;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_OUT_GO;
      end
      ST_OUT_GO: begin
        cmd.start = 1'b1;
        state_nxt = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (status.scale_done) begin
          cmd.cap_out = 1'b1;
          state_nxt   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

  // An accepted item always starts its first pass.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_PSAMP_GO))
    else $error("accepted item did not start processing");

  // The rescaling unit only finishes while a pass is awaited.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    status.scale_done |-> (state_r == ST_PSAMP_WAIT || state_r == ST_EXP_WAIT ||
                           state_r == ST_ACT_WAIT || state_r == ST_OUT_WAIT))
    else $error("rescale finished with no pass pending");

  // A pass never completes in the cycle after it starts.
  a_no_instant_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !status.scale_done)
    else $error("rescale finished too early");

endmodule

`default_nettype wire

// ===== rtl/audio_pts_unwrap_timestamp_tracker.sv =====
`default_nettype none

// Audio timestamp tracker. One item per decoded audio frame; each item gives
// exactly one result (emit flag, microsecond time from the sample clock and a
// resync flag). Items are handled one at a time. A frame with a timestamp
// takes four rescaling passes through a shared shift-add multiplier and
// restoring divider; a frame without a timestamp takes one pass. A stalled
// result holds up the next item only when that item finishes before the
// result is taken. The result register lets the next item be taken while a
// result still waits. Configuration is to be written by the user only while
// no item is in flight; the block itself does not enforce this.
module audio_pts_unwrap_timestamp_tracker #(
  parameter int unsigned PTS_BITS  = 33,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [apts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [apts_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [PTS_BITS-1:0]              in_pts,
  input  wire logic                             in_pts_valid,
  input  wire logic [apts_pkg::CNT_W-1:0]       in_sample_count,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_emit,
  output logic [apts_pkg::OUT_W-1:0]            out_time_us,
  output logic                                  out_resynced
);

  apts_pkg::dp_cmd_t    cmd;
  apts_pkg::dp_status_t status;

  apts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  apts_dp #(
    .PTS_BITS  (PTS_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_pts          (in_pts),
    .in_pts_valid    (in_pts_valid),
    .in_sample_count (in_sample_count),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_emit        (out_emit),
    .out_time_us     (out_time_us),
    .out_resynced    (out_resynced),
    .cmd             (cmd),
    .status          (status)
  );

endmodule

`default_nettype wire

// ===== tb/sv/audio_pts_unwrap_timestamp_tracker_checker.sv =====
`timescale 1ns / 1ps

module audio_pts_unwrap_timestamp_tracker_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [apts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apts_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [32:0]                     in_pts,
  input  logic                            in_pts_valid,
  input  logic [apts_pkg::CNT_W-1:0]      in_sample_count,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            out_emit,
  input  logic [apts_pkg::OUT_W-1:0]      out_time_us,
  input  logic                            out_resynced,
  output int                              errors,
  output int                              pending
);

  localparam logic [63:0] TIME_LIMIT = (64'd1 << 48) - 64'd1;
  localparam logic [63:0] EPOCH      = 64'd1 << 33;
  localparam longint      HALF_EPOCH = longint'(EPOCH >> 1);
  localparam int          RING_DEPTH = 256;

  typedef struct {
    bit        emit;
    bit [47:0] time_us;
    bit        resynced;
  } frame_result_t;

  // Expected results in order, written at the tail and read at the head.
  frame_result_t frame_ring[RING_DEPTH];
  int            ring_head;
  int            ring_tail;

  // Shadow copy of the configuration.
  logic [63:0] tick_num, tick_den, rate, gap_sec;
  bit          unwrap_on, regress_ok;

  // Shadow copy of the tracking state.
  logic [63:0] run_pts, samp_clk, last_time;
  bit          run_seen, frame_seen, last_set;

  assign pending = ring_tail - ring_head;

  initial begin
    errors = 0;
    ring_head = 0;
    ring_tail = 0;
  end

  // Rounded v*m/d, ties away from zero, saturated to the time range.
  function automatic logic [63:0] rescale(logic [63:0] v, logic [63:0] m, logic [63:0] d);
    logic [127:0] acc;
    logic [127:0] q;
    acc = {64'd0, v} * {64'd0, m} + {64'd0, d >> 1};
    q = acc / {64'd0, d};
    if (q > {64'd0, TIME_LIMIT}) return TIME_LIMIT;
    return q[63:0];
  endfunction

  // Follows the stream timestamp across 33-bit rollovers.
  function automatic logic [63:0] track_rollover(logic [32:0] pts);
    longint      step;
    logic [63:0] mag;
    if (!run_seen) begin
      run_seen = 1;
      run_pts = {31'd0, pts};
      return run_pts;
    end
    step = longint'({31'd0, pts}) - longint'(run_pts & (EPOCH - 1));
    if (step > HALF_EPOCH) step -= longint'(EPOCH);
    else if (step < -HALF_EPOCH) step += longint'(EPOCH);
    if (step < 0) begin
      mag = 64'(-step);
      run_pts = (mag > run_pts) ? 64'd0 : run_pts - mag;
    end else begin
      mag = 64'(step);
      run_pts = (TIME_LIMIT - run_pts < mag) ? TIME_LIMIT : run_pts + mag;
    end
    return run_pts;
  endfunction

  // Works out the result of one frame and advances the sample clock.
  function automatic frame_result_t track_frame(logic [32:0] pts, bit has_pts,
                                                logic [15:0] count);
    frame_result_t r;
    logic [63:0]   den, sr, p, p_samples, want_us, got_us, drift;
    den = (tick_den == 0) ? 64'd1 : tick_den;
    sr = (rate == 0) ? 64'd1 : rate;
    r.resynced = 0;
    r.emit = 0;
    if (has_pts) begin
      p = unwrap_on ? track_rollover(pts) : {31'd0, pts};
      p_samples = rescale(p, tick_num * sr, den);
      if (!frame_seen) samp_clk = p_samples;
      want_us = rescale(samp_clk, 64'd1000000, sr);
      got_us = rescale(p, tick_num * 64'd1000000, den);
      drift = (want_us > got_us) ? want_us - got_us : got_us - want_us;
      if (drift > gap_sec * 64'd1000000) begin
        samp_clk = p_samples;
        r.resynced = 1;
      end
    end
    want_us = rescale(samp_clk, 64'd1000000, sr);
    r.time_us = want_us[47:0];
    if (count != 0) begin
      r.emit = regress_ok || !last_set || (want_us > last_time);
      if (r.emit) begin
        last_time = want_us;
        last_set = 1;
      end
      samp_clk = (TIME_LIMIT - samp_clk < 64'(count)) ? TIME_LIMIT : samp_clk + 64'(count);
    end
    frame_seen = 1;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Watch configuration writes, accepted items and accepted results.
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      tick_num = 1; tick_den = 90000; rate = 48000; gap_sec = 5;
      unwrap_on = 0; regress_ok = 0;
      run_pts = 0; samp_clk = 0; last_time = 0;
      run_seen = 0; frame_seen = 0; last_set = 0;
      ring_head = 0;
      ring_tail = 0;
    end else begin
      if (cfg_we) begin
        case (apts_pkg::cfg_reg_t'(cfg_index))
          apts_pkg::REG_TICK_NUM:      tick_num = 64'(cfg_wdata[15:0]);
          apts_pkg::REG_TICK_DEN:      tick_den = 64'(cfg_wdata[30:0]);
          apts_pkg::REG_SAMPLE_RATE:   rate = 64'(cfg_wdata[19:0]);
          apts_pkg::REG_GAP_SECONDS:   gap_sec = 64'(cfg_wdata[11:0]);
          apts_pkg::REG_UNWRAP_EN:     unwrap_on = cfg_wdata[0];
          apts_pkg::REG_ALLOW_REGRESS: regress_ok = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        frame_ring[ring_tail % RING_DEPTH] =
          track_frame(in_pts, in_pts_valid, in_sample_count);
        ring_tail++;
      end
      if (out_valid && !out_stall) begin
        if (ring_tail == ring_head) begin
          report_mismatch("result with no frame outstanding", 64'd1, 64'd0);
        end else begin
          want = frame_ring[ring_head % RING_DEPTH];
          ring_head++;
          if (out_emit != want.emit) report_mismatch("emit", out_emit, want.emit);
          if (out_time_us != want.time_us)
            report_mismatch("time_us", out_time_us, want.time_us);
          if (out_resynced != want.resynced)
            report_mismatch("resynced", out_resynced, want.resynced);
        end
      end
    end
  end

endmodule

// ===== tb/sv/audio_pts_unwrap_timestamp_tracker_test.sv =====
`timescale 1ns / 1ps

module audio_pts_unwrap_timestamp_tracker_test;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [32:0] PTS_TOP = 33'h1_FFFF_FFFF;

  logic                            clk, rst_n;
  logic                            cfg_we;
  logic [apts_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [apts_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_valid, in_stall;
  logic [32:0]                     in_pts;
  logic                            in_pts_valid;
  logic [apts_pkg::CNT_W-1:0]      in_sample_count;
  logic                            out_valid, out_stall;
  logic                            out_emit;
  logic [apts_pkg::OUT_W-1:0]      out_time_us;
  logic                            out_resynced;
  int                              errors, pending;

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_req = 0;
  bit  holding = 0;
  int  quiet_cycles = 0;
  logic [32:0] pts_cursor;

  audio_pts_unwrap_timestamp_tracker DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_pts(in_pts),
    .in_pts_valid(in_pts_valid), .in_sample_count(in_sample_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_emit(out_emit),
    .out_time_us(out_time_us), .out_resynced(out_resynced)
  );

  audio_pts_unwrap_timestamp_tracker_checker frame_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_pts(in_pts),
    .in_pts_valid(in_pts_valid), .in_sample_count(in_sample_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_emit(out_emit),
    .out_time_us(out_time_us), .out_resynced(out_resynced),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial out_stall = 0;
  always @(posedge clk) begin
    out_stall <= holding || ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    holding = 1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding = 0;
  end

  // Watchdog on cycles with no traffic on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("audio_pts_unwrap_timestamp_tracker_test: FAIL");
      $finish;
    end
  end

  // Offer one frame and hold it until it is taken.
  task automatic send_frame(logic [32:0] pts, logic has_pts, logic [15:0] count);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    in_pts <= pts;
    in_pts_valid <= has_pts;
    in_sample_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop offering and let the block drain before touching registers.
  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] num, logic [30:0] den, logic [19:0] sr,
                            logic [11:0] gap, logic unwrap, logic regress);
    cfg_we <= 1;
    cfg_index <= apts_pkg::REG_TICK_NUM;      cfg_wdata <= 31'(num);     @(posedge clk);
    cfg_index <= apts_pkg::REG_TICK_DEN;      cfg_wdata <= den;          @(posedge clk);
    cfg_index <= apts_pkg::REG_SAMPLE_RATE;   cfg_wdata <= 31'(sr);      @(posedge clk);
    cfg_index <= apts_pkg::REG_GAP_SECONDS;   cfg_wdata <= 31'(gap);     @(posedge clk);
    cfg_index <= apts_pkg::REG_UNWRAP_EN;     cfg_wdata <= 31'(unwrap);  @(posedge clk);
    cfg_index <= apts_pkg::REG_ALLOW_REGRESS; cfg_wdata <= 31'(regress); @(posedge clk);
    cfg_we <= 0;
  endtask

  // Mostly steady frame cadence, with jumps, rollovers, gaps and empty frames.
  task automatic send_random_frame;
    logic [15:0] count;
    logic        has_pts;
    int          pick;
    pick = $urandom_range(99);
    count = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd1024;
    if (pick < 5) count = 0;
    has_pts = (pick >= 5 && pick < 15) ? 1'b0 : 1'b1;
    if (pick >= 95) pts_cursor = {1'($urandom), 32'($urandom)};
    else if (pick >= 92) pts_cursor = PTS_TOP - 33'($urandom_range(5000));
    else if (pick >= 89) pts_cursor = pts_cursor - 33'($urandom_range(20000));
    else pts_cursor = pts_cursor + 33'($urandom_range(3000));
    send_frame(pts_cursor, has_pts, count);
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_pts = '0; in_pts_valid = 0; in_sample_count = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed frames under the reset configuration.
    send_frame(33'd0, 1, 16'd0);
    send_frame(33'd1920, 1, 16'd1024);
    send_frame(33'd3840, 1, 16'hFFFF);
    send_frame(33'd0, 0, 16'd1);
    send_frame(33'd3840, 1, 16'd1);
    send_frame(33'd9000000, 1, 16'd1024);
    send_frame(PTS_TOP, 1, 16'hFFFF);
    drain();

    // Rollover forward and back, then clamping at zero, then regressions.
    set_config(16'd1, 31'd90000, 20'd48000, 12'd5, 1'b1, 1'b0);
    send_frame(PTS_TOP - 33'd99, 1, 16'd1024);
    send_frame(33'd50, 1, 16'd1024);
    send_frame(PTS_TOP - 33'd9, 1, 16'd1024);
    pts_cursor = PTS_TOP - 33'd9;
    repeat (4) begin
      pts_cursor = pts_cursor - 33'h0_FFFF_FFFF;
      send_frame(pts_cursor, 1, 16'd1024);
    end
    drain();
    set_config(16'd1, 31'd90000, 20'd48000, 12'd5, 1'b1, 1'b1);
    send_frame(33'd100, 1, 16'd1);
    send_frame(33'd100, 1, 16'd0);
    send_frame(33'd100, 0, 16'd1);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(16'd1, 31'd90000, 20'd48000, 12'd5, 1'b1, 1'b0);
        1: set_config(16'hFFFF, 31'h7FFF_FFFF, 20'd768000, 12'd4095, 1'b0, 1'b1);
        2: set_config(16'd1, 31'd1, 20'd1, 12'd0, 1'b1, 1'b1);
        3: set_config(16'($urandom_range(1, 65535)), 31'($urandom_range(1, 32'h7FFF_FFFF)),
                      20'($urandom_range(1, 768000)), 12'($urandom), 1'b1, 1'b0);
        4: set_config(16'd0, 31'd0, 20'd0, 12'd0, 1'b0, 1'b0);
        default: set_config(16'd1, 31'd90000, 20'd44100, 12'd1, 1'b1, 1'b0);
      endcase
      if (phase < 2) begin
        send_idle_pct = 16; recv_idle_pct = 66;
      end else if (phase < 4) begin
        send_idle_pct = 66; recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      pts_cursor = {1'($urandom), 32'($urandom)};
      for (int n = 0; n < 250; n++) begin
        if (phase == 0 && n == 20) hold_req = 1;
        send_random_frame();
      end
      drain();
    end

    if (errors == 0) begin
      $display("audio_pts_unwrap_timestamp_tracker_test: PASS");
    end else begin
      $display("audio_pts_unwrap_timestamp_tracker_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/apts_pkg.sv
rtl/apts_scaler.sv
rtl/apts_dp.sv
rtl/apts_ctrl.sv
rtl/audio_pts_unwrap_timestamp_tracker.sv
tb/sv/audio_pts_unwrap_timestamp_tracker_checker.sv
tb/sv/audio_pts_unwrap_timestamp_tracker_test.sv
